// File: design/tzk_pkg.sv
package tzk_pkg;

   localparam int ZONE_COUNT = 4;
   localparam int COORD_W    = 8;
   localparam int FINGER_W   = 8;
   localparam int KEY_W      = 9;
   localparam int ZONE_IDX_W = 2;
   localparam int ACTION_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 36;

   // event kinds
   localparam logic [ACTION_W-1:0] ACT_DOWN   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UP     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MOTION = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_OTHER  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEYS   = 3'd4;

   // default layout
   localparam logic [31:0] LEFT_RESET   = 32'd3365158154;
   localparam logic [31:0] TOP_RESET    = 32'd3014898611;
   localparam logic [31:0] WIDTH_RESET  = 32'd774778414;
   localparam logic [31:0] HEIGHT_RESET = 32'd1027423549;
   localparam logic [35:0] KEYS_RESET   = 36'd5782937168;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COORD_W-1:0]  touch_x;
      logic [COORD_W-1:0]  touch_y;
      logic [FINGER_W-1:0] finger;
   } touch_beat_type;

   typedef struct packed {
      logic [KEY_W-1:0]      key_code;
      logic                  pressed;
      logic [ZONE_IDX_W-1:0] zone_index;
      logic                  last;
   } key_beat_type;

endpackage

// File: design/tzk_touch_if.sv
interface tzk_touch_if import tzk_pkg::*; ();
   logic           valid;
   logic           ready;
   touch_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/tzk_key_if.sv
interface tzk_key_if import tzk_pkg::*; ();
   logic         valid;
   logic         ready;
   key_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/touch_zone_key_mapper_unit.sv
// touch zone key mapper
// req_ch carries touch beats (action, touch_x, touch_y, finger); rsp_ch carries
// key beats (key_code, pressed, zone_index, last), lowest zone first, with last
// set on the final key beat of a touch. a touch that changes no zone gives no beat.
// csr_* writes the zone layout and key registers; write only while idle.
// a touch is evaluated against the zone state in the accepting cycle and its
// events are parked as a per-zone event mask; the mask drains one zone per
// cycle into the output register while the receiver takes beats.
// the first key beat of a touch is parked in the event mask register and only
// then loaded into the output register.
// throughput: one touch per cycle when touches cause at most one key beat and
// the receiver takes them; a touch causing several key beats holds the input
// while the single output register drains one beat per cycle from the mask.
// a new touch is taken in the cycle the last parked event moves to the output
// register, so the output stage and mask stage overlap.
// reset: all zones idle, owners zero, layout back to defaults, no beat pending.
// receiver stall: the output beat holds, the mask stops draining and req_ch
// ready drops once events are parked.
module touch_zone_key_mapper_unit import tzk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tzk_touch_if.sink             req_ch,
   tzk_key_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // layout registers
   logic [31:0] left_ff, top_ff, width_ff, height_ff;
   logic [35:0] keys_ff;

   // zone state
   logic [ZONE_COUNT-1:0]               active_ff, active_in;
   logic [ZONE_COUNT-1:0][FINGER_W-1:0] owner_ff, owner_in;

   // parked events of the touch in flight
   logic [ZONE_COUNT-1:0] pend_ff, pend_in;
   logic [ZONE_COUNT-1:0] press_ff, press_in;

   // output stage
   logic         rsp_valid_ff, rsp_valid_in;
   key_beat_type rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  pop;
   logic [ZONE_COUNT-1:0] ev_mask, ev_press;
   logic [ZONE_COUNT-1:0] sel_hot;
   logic [ZONE_COUNT-1:0] remain;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= LEFT_RESET;
         top_ff    <= TOP_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         keys_ff   <= KEYS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEFT:   left_ff   <= csr_wdata[31:0];
            REG_TOP:    top_ff    <= csr_wdata[31:0];
            REG_WIDTH:  width_ff  <= csr_wdata[31:0];
            REG_HEIGHT: height_ff <= csr_wdata[31:0];
            REG_KEYS:   keys_ff   <= csr_wdata;
            default: begin
               // writes beyond the list are dropped
            end
         endcase
      end
   end

   // drain: one parked zone moves out when the output slot is free or leaving
   assign pop = (pend_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);

   // take a touch once nothing would remain parked after this cycle
   assign req_ch.ready = (pend_ff == '0) || (pop && $onehot(pend_ff));
   assign req_fire     = req_ch.valid && req_ch.ready;

   // per-zone hit test and ownership rules
   always_comb begin
      logic [COORD_W-1:0] l, t;
      logic [COORD_W:0]   r, b;
      logic               in_zone, owned;
      ev_mask   = '0;
      ev_press  = '0;
      active_in = active_ff;
      owner_in  = owner_ff;
      for (int i = 0; i < ZONE_COUNT; i++) begin
         l = left_ff[COORD_W*i +: COORD_W];
         t = top_ff[COORD_W*i +: COORD_W];
         r = {1'b0, l} + {1'b0, width_ff[COORD_W*i +: COORD_W]};
         b = {1'b0, t} + {1'b0, height_ff[COORD_W*i +: COORD_W]};
         in_zone = (req_ch.data.touch_x >= l) && ({1'b0, req_ch.data.touch_x} <= r) &&
                   (req_ch.data.touch_y >= t) && ({1'b0, req_ch.data.touch_y} <= b);
         owned   = active_ff[i] && (owner_ff[i] == req_ch.data.finger);
         unique case (req_ch.data.action)
            ACT_DOWN: begin
               if (in_zone && !active_ff[i]) begin
                  ev_mask[i]  = 1'b1;
                  ev_press[i] = 1'b1;
               end
            end
            ACT_UP: begin
               ev_mask[i] = owned;
            end
            ACT_MOTION: begin
               ev_mask[i] = owned && !in_zone;
            end
            ACT_OTHER: begin
               // ignored
            end
            default: begin
            end
         endcase
         if (req_fire && ev_mask[i]) begin
            active_in[i] = ev_press[i];
            if (ev_press[i]) begin
               owner_in[i] = req_ch.data.finger;
            end
         end
      end
   end

   // lowest parked zone goes first
   always_comb begin
      logic found;
      found   = 1'b0;
      sel_hot = '0;
      for (int i = 0; i < ZONE_COUNT; i++) begin
         if (pend_ff[i] && !found) begin
            sel_hot[i] = 1'b1;
            found      = 1'b1;
         end
      end
   end

   assign remain = pend_ff & ~sel_hot;

   always_comb begin
      pend_in  = pend_ff;
      press_in = press_ff;
      if (pop) begin
         pend_in = remain;
      end
      if (req_fire) begin
         pend_in  = ev_mask;
         press_in = ev_press;
      end
   end

   // build the outgoing key beat
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (pop) begin
         rsp_data_in.last = (remain == '0);
         for (int i = 0; i < ZONE_COUNT; i++) begin
            if (sel_hot[i]) begin
               rsp_data_in.key_code   = keys_ff[KEY_W*i +: KEY_W];
               rsp_data_in.pressed    = press_ff[i];
               rsp_data_in.zone_index = ZONE_IDX_W'(i);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         owner_ff     <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         owner_ff     <= owner_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      press_ff    <= press_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // a touch never lands on events still parked
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (pend_ff == '0) || (pop && $onehot(pend_ff)))
      else $error("touch accepted over parked events");

   // events of an accepted touch are parked next cycle
   a_park: assert property (@(posedge clock) disable iff (reset)
      req_fire && (ev_mask != '0) |=> (pend_ff != '0))
      else $error("events of accepted touch lost");

   // a drained zone always shows up in the output register
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("drained event not presented");

   // the final beat of a touch leaves nothing parked behind
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      pop && (remain == '0) && !req_fire |=> rsp_data_ff.last && (pend_ff == '0))
      else $error("last flag out of step with parked events");

endmodule
